/* rtl/u8d_pkg.sv */
// Shared types, constants and decode functions for the UTF-8 byte stream decoder.
package u8d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] GROUP_MAX = 3'd4;

    localparam logic [7:0] BOM_BYTE0 = 8'hEF;
    localparam logic [7:0] BOM_BYTE1 = 8'hBB;
    localparam logic [7:0] BOM_BYTE2 = 8'hBF;

    typedef logic [3:0][7:0] group_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        code_valid;
        logic        string_aborted;
        logic        run_last;
    } result_t;

    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } record_t;

    function automatic logic is_bom(group_t g, logic [2:0] n);
        return (n == 3'd3) && (g[0] == BOM_BYTE0) && (g[1] == BOM_BYTE1) &&
               (g[2] == BOM_BYTE2);
    endfunction

    function automatic logic [20:0] decode_group(group_t g, logic [2:0] n);
        logic [20:0] cp;
        case (n)
            3'd1:    cp = {14'd0, g[0][6:0]};
            3'd2:    cp = {10'd0, g[0][4:0], g[1][5:0]};
            3'd3:    cp = {5'd0, g[0][3:0], g[1][5:0], g[2][5:0]};
            3'd4:    cp = {g[0][2:0], g[1][5:0], g[2][5:0], g[3][5:0]};
            default: cp = 21'd0;
        endcase
        return cp;
    endfunction

endpackage

/* rtl/utf8_byte_stream_decoder.sv */
// Top level of the UTF-8 byte stream decoder.
// Takes one byte per cycle on s_axis (tlast marks the end of a string) and returns
// code points on m_axis. An input transaction is accepted in the cycle it arrives while
// the record queue (QUEUE_DEPTH entries) has room; the output register sends one result
// per cycle while m_axis_tready is high, so a byte that both closes a group and ends the
// string yields two results, and a byte that only joins a group yields none. Each record
// passes through the record queue and then the output register.
module utf8_byte_stream_decoder
#(
    parameter int QUEUE_DEPTH = u8d_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [0] code_valid, [1] string_aborted
    output logic        m_axis_tlast
);

    logic             push;
    u8d_pkg::record_t push_record;
    logic             queue_full;
    logic             pop;
    logic             head_valid;
    u8d_pkg::record_t head_record;
    u8d_pkg::result_t out_result;

    u8d_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .data_byte     (s_axis_tdata),
        .end_of_string (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_record   (push_record)
    );

    u8d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_record (push_record),
        .full        (queue_full),
        .pop         (pop),
        .head_valid  (head_valid),
        .head_record (head_record)
    );

    u8d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_record (head_record),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = {3'd0, out_result.code_point};
    assign m_axis_tuser = {out_result.string_aborted, out_result.code_valid};
    assign m_axis_tlast = out_result.run_last;

endmodule

/* rtl/u8d_front.sv */
// Front end: gathers bytes into groups and builds the result record of each item.
module u8d_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_string,
    input  logic               queue_full,
    output logic               push,
    output u8d_pkg::record_t   push_record
);

    u8d_pkg::group_t pending_reg;
    u8d_pkg::group_t pending_next;
    logic [2:0]      count_reg;
    logic [2:0]      count_next;
    logic            aborted_reg;
    logic            aborted_next;

    logic            accept;
    logic            byte_ok;
    logic            closes;
    logic            close_grp;
    logic            close_res;
    u8d_pkg::group_t base_g;
    logic [2:0]      base_n;
    u8d_pkg::group_t g_after;
    logic [2:0]      n_after;
    logic            ab_after;
    u8d_pkg::result_t close_result;
    u8d_pkg::result_t end_result;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        byte_ok   = (data_byte != 8'd0) && !aborted_reg;
        closes    = !data_byte[7] || (data_byte[7:6] == 2'b11);
        close_grp = byte_ok && closes && (count_reg != 3'd0);
        close_res = close_grp && !u8d_pkg::is_bom(pending_reg, count_reg);

        base_g = close_grp ? '0 : pending_reg;
        base_n = close_grp ? 3'd0 : count_reg;

        g_after  = pending_reg;
        n_after  = count_reg;
        ab_after = aborted_reg;
        if (byte_ok)
        begin
            if (base_n >= u8d_pkg::GROUP_MAX)
            begin
                g_after  = '0;
                n_after  = 3'd0;
                ab_after = 1'b1;
            end
            else
            begin
                g_after              = base_g;
                g_after[base_n[1:0]] = data_byte;
                n_after              = 3'(base_n + 3'd1);
            end
        end

        close_result.code_point     = u8d_pkg::decode_group(pending_reg, count_reg);
        close_result.code_valid     = 1'b1;
        close_result.string_aborted = 1'b0;
        close_result.run_last       = 1'b0;

        end_result.code_point     = 21'd0;
        end_result.code_valid     = 1'b0;
        end_result.string_aborted = 1'b0;
        end_result.run_last       = 1'b1;
        if (ab_after)
        begin
            end_result.string_aborted = 1'b1;
        end
        else if ((n_after != 3'd0) && !u8d_pkg::is_bom(g_after, n_after))
        begin
            end_result.code_point = u8d_pkg::decode_group(g_after, n_after);
            end_result.code_valid = 1'b1;
        end

        if (close_res)
        begin
            push_record.first  = close_result;
            push_record.second = end_result;
            push_record.two    = end_of_string;
        end
        else
        begin
            push_record.first  = end_result;
            push_record.second = end_result;
            push_record.two    = 1'b0;
        end
        push = accept && (close_res || end_of_string);

        if (end_of_string)
        begin
            pending_next = '0;
            count_next   = 3'd0;
            aborted_next = 1'b0;
        end
        else
        begin
            pending_next = g_after;
            count_next   = n_after;
            aborted_next = ab_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            count_reg   <= 3'd0;
            aborted_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
            aborted_reg <= aborted_next;
        end
    end

endmodule

/* rtl/u8d_queue.sv */
// Short record queue between the front end and the output stage.
module u8d_queue
#(
    parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u8d_pkg::record_t push_record,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output u8d_pkg::record_t head_record
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    u8d_pkg::record_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full        = (count_reg == FULL_COUNT);
    assign head_valid  = (count_reg != '0);
    assign head_record = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_record;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_SLOT) ? '0 : AW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_SLOT) ? '0 : AW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/u8d_back.sv */
// Output stage: unpacks each record into one or two result transactions.
module u8d_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  u8d_pkg::record_t head_record,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output u8d_pkg::result_t out_result
);

    logic             out_valid_reg;
    logic             out_valid_next;
    u8d_pkg::result_t out_result_reg;
    u8d_pkg::result_t out_result_next;
    logic             second_reg;
    logic             second_next;
    logic             load;

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign load       = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        second_next     = second_reg;
        pop             = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (head_record.two && !second_reg)
                begin
                    out_result_next = head_record.first;
                    second_next     = 1'b1;
                end
                else
                begin
                    out_result_next = second_reg ? head_record.second : head_record.first;
                    second_next     = 1'b0;
                    pop             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_result_reg <= out_result_next;
    end

`ifndef NO_ASSERTIONS
    a_second_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> head_valid)
        else $error("second half pending with empty queue");

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid && load)
        else $error("pop without a head record or output slot");

    a_abort_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.string_aborted |->
            out_result_reg.run_last && !out_result_reg.code_valid)
        else $error("abort flag on a non-final or valid result");
`endif

endmodule

/* tb/utf8_decode_checker.sv */
// Checker for the UTF-8 byte stream decoder: predicts code points from accepted bytes and compares.
`timescale 1ns / 100ps

module utf8_decode_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] out_data,   // [20:0] code_point, [23:21] zero
    input  logic [1:0]  out_flags,  // [0] code_valid, [1] string_aborted
    input  logic        out_last,
    output int          failures,
    output int          due,
    output int          checked,
    output int          aborted_strings,
    output int          bom_drops
);

    logic [7:0]       grp [4];
    logic [2:0]       grp_n = 3'd0;
    logic             cut = 1'b0;
    u8d_pkg::result_t code_points_due [$];
    u8d_pkg::result_t next_due;

    int fail_cnt = 0;
    int due_cnt = 0;
    int check_cnt = 0;
    int abort_cnt = 0;
    int bom_cnt = 0;

    assign failures        = fail_cnt;
    assign due             = due_cnt;
    assign checked         = check_cnt;
    assign aborted_strings = abort_cnt;
    assign bom_drops       = bom_cnt;

    function automatic logic group_is_bom();
        return grp_n == 3'd3 && grp[0] == u8d_pkg::BOM_BYTE0 &&
               grp[1] == u8d_pkg::BOM_BYTE1 && grp[2] == u8d_pkg::BOM_BYTE2;
    endfunction

    function automatic logic [20:0] group_code();
        logic [20:0] cp;
        cp = '0;
        case (grp_n)
            3'd1: cp = 21'(grp[0] & 8'h7F);
            3'd2: cp = (21'(grp[0] & 8'h1F) << 6) | 21'(grp[1] & 8'h3F);
            3'd3: cp = (21'(grp[0] & 8'h0F) << 12) | (21'(grp[1] & 8'h3F) << 6) |
                       21'(grp[2] & 8'h3F);
            3'd4: cp = (21'(grp[0] & 8'h07) << 18) | (21'(grp[1] & 8'h3F) << 12) |
                       (21'(grp[2] & 8'h3F) << 6) | 21'(grp[3] & 8'h3F);
            default: cp = '0;
        endcase
        return cp;
    endfunction

    task automatic clear_group();
        for (int i = 0; i < 4; i++)
        begin
            grp[i] = 8'h00;
        end
        grp_n = 3'd0;
    endtask

    task automatic push_due(input logic [20:0] cp, input logic valid, input logic aborted,
                            input logic last);
        u8d_pkg::result_t r;
        r.code_point     = cp;
        r.code_valid     = valid;
        r.string_aborted = aborted;
        r.run_last       = last;
        code_points_due.push_back(r);
    endtask

    task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
        $display("%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_cnt++;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic closes;
        if (b != 8'h00 && !cut)
        begin
            closes = !b[7] || b[7:6] == 2'b11;
            if (closes && grp_n != 3'd0)
            begin
                if (group_is_bom())
                begin
                    bom_cnt++;
                end
                else
                begin
                    push_due(group_code(), 1'b1, 1'b0, 1'b0);
                end
                clear_group();
            end
            if (grp_n >= u8d_pkg::GROUP_MAX)
            begin
                clear_group();
                cut = 1'b1;
            end
            else
            begin
                grp[grp_n[1:0]] = b;
                grp_n++;
            end
        end
        if (last)
        begin
            if (cut)
            begin
                push_due('0, 1'b0, 1'b1, 1'b1);
                abort_cnt++;
            end
            else if (grp_n != 3'd0 && !group_is_bom())
            begin
                push_due(group_code(), 1'b1, 1'b0, 1'b1);
            end
            else
            begin
                if (group_is_bom())
                begin
                    bom_cnt++;
                end
                push_due('0, 1'b0, 1'b0, 1'b1);
            end
            clear_group();
            cut = 1'b0;
        end
    endtask

    task automatic compare_result();
        if (code_points_due.size() == 0)
        begin
            report("result with nothing due", out_data, '0);
        end
        else
        begin
            next_due = code_points_due.pop_front();
            check_cnt++;
            if (out_data[20:0] != next_due.code_point)
            begin
                report("code_point", 24'(out_data[20:0]), 24'(next_due.code_point));
            end
            if (out_flags[0] != next_due.code_valid)
            begin
                report("code_valid", 24'(out_flags[0]), 24'(next_due.code_valid));
            end
            if (out_flags[1] != next_due.string_aborted)
            begin
                report("string_aborted", 24'(out_flags[1]), 24'(next_due.string_aborted));
            end
            if (out_last != next_due.run_last)
            begin
                report("run_last", 24'(out_last), 24'(next_due.run_last));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_group();
            cut = 1'b0;
            code_points_due.delete();
            due_cnt = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(in_byte, in_last);
            end
            if (out_valid && out_ready)
            begin
                compare_result();
            end
            due_cnt = code_points_due.size();
        end
    end

endmodule

/* tb/utf8_byte_stream_decoder_test.sv */
// Top of the UTF-8 byte stream decoder testbench: clock, reset, byte strings and verdict.
`timescale 1ns / 100ps

module utf8_byte_stream_decoder_test;

    localparam int RANDOM_ITEMS = 1950;
    localparam int PHASE_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 400000;

    localparam int SEND_IDLE  [4] = '{0, 56, 0, 36};
    localparam int RECV_STALL [4] = '{0, 0, 56, 36};

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int idle_pct = 0;
    int stall_pct = 0;
    int byte_count = 0;
    int string_count = 0;
    int cycles = 0;
    int failures, due, checked, aborted_strings, bom_drops;

    logic [8:0] directed [$];
    logic [7:0] msg_bytes [$];

    utf8_byte_stream_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_decode_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .in_byte         (s_axis_tdata),
        .in_last         (s_axis_tlast),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (m_axis_tdata),
        .out_flags       (m_axis_tuser),
        .out_last        (m_axis_tlast),
        .failures        (failures),
        .due             (due),
        .checked         (checked),
        .aborted_strings (aborted_strings),
        .bom_drops       (bom_drops)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycles, due);
            $display("FAIL utf8_byte_stream_decoder");
            $finish;
        end
    end

    function automatic logic [7:0] cont_byte();
        return 8'(8'h80 | $urandom_range(63));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        byte_count++;
        if (last)
        begin
            string_count++;
        end
    endtask

    // hold off until every due result has come, then let in-flight bytes settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (due != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic make_string();
        int kind;
        msg_bytes.delete();
        repeat ($urandom_range(12, 1))
        begin
            kind = $urandom_range(99);
            if (kind < 40)
            begin
                msg_bytes.push_back(8'($urandom_range(127, 1)));
            end
            else if (kind < 55)
            begin
                msg_bytes.push_back(8'(8'hC0 | $urandom_range(31)));
                msg_bytes.push_back(cont_byte());
            end
            else if (kind < 68)
            begin
                msg_bytes.push_back(8'(8'hE0 | $urandom_range(15)));
                repeat (2) msg_bytes.push_back(cont_byte());
            end
            else if (kind < 78)
            begin
                msg_bytes.push_back(8'(8'hF0 | $urandom_range(7)));
                repeat (3) msg_bytes.push_back(cont_byte());
            end
            else if (kind < 83)
            begin
                msg_bytes.push_back(u8d_pkg::BOM_BYTE0);
                msg_bytes.push_back(u8d_pkg::BOM_BYTE1);
                msg_bytes.push_back(u8d_pkg::BOM_BYTE2);
            end
            else if (kind < 88)
            begin
                repeat ($urandom_range(3, 1)) msg_bytes.push_back(cont_byte());
            end
            else if (kind < 92)
            begin
                msg_bytes.push_back(8'($urandom_range(255, 192)));
                repeat ($urandom_range(6, 4)) msg_bytes.push_back(cont_byte());
            end
            else if (kind < 96)
            begin
                msg_bytes.push_back(8'h00);
            end
            else
            begin
                msg_bytes.push_back(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_string(input logic zero_end);
        for (int i = 0; i < msg_bytes.size(); i++)
        begin
            send_byte(msg_bytes[i], !zero_end && i == msg_bytes.size() - 1);
        end
        if (zero_end || msg_bytes.size() == 0)
        begin
            send_byte(8'h00, 1'b1);
        end
    endtask

    initial
    begin
        int phase;
        int cur_phase;
        cur_phase = -1;
        // {end_of_string, data_byte}
        directed = '{9'h100,
                     9'h07F, 9'h000, 9'h0C3, 9'h1BF,
                     9'h0E2, 9'h082, 9'h0AC, 9'h0F0, 9'h09F, 9'h098, 9'h180,
                     9'h0EF, 9'h0BB, 9'h0BF, 9'h141,
                     9'h0EF, 9'h0BB, 9'h1BF,
                     9'h0FF, 9'h080, 9'h080, 9'h080, 9'h0BF, 9'h100};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed[i])
        begin
            send_byte(directed[i][7:0], directed[i][8]);
        end

        while (byte_count < directed.size() + RANDOM_ITEMS)
        begin
            phase = ((byte_count - directed.size()) / PHASE_ITEMS) % 4;
            if (phase != cur_phase)
            begin
                drain();
                cur_phase = phase;
                idle_pct  = SEND_IDLE[phase];
                stall_pct = RECV_STALL[phase];
            end
            if ($urandom_range(19) == 0)
            begin
                msg_bytes.delete();
                send_string(1'b1);
            end
            else
            begin
                make_string();
                send_string($urandom_range(7) == 0);
            end
        end

        drain();
        repeat (16) @(posedge clk);

        $display("sent %0d bytes in %0d strings under four send idle / receive stall mixes",
                 byte_count, string_count);
        $display("checked %0d results, %0d aborted strings, %0d byte order marks dropped",
                 checked, aborted_strings, bom_drops);
        if (failures == 0)
        begin
            $display("PASS utf8_byte_stream_decoder");
        end
        else
        begin
            $display("FAIL utf8_byte_stream_decoder");
        end
        $finish;
    end

endmodule
